// ===== rtl/dcs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcs_pkg
// Shared widths, operation codes, word types and helpers for the darkest
// circle selector.
// ----------------------------------------------------------------------------
package dcs_pkg;

   // Default number of circle slots (cells in the chain)
   localparam int MAX_CIRCLES_DEF = 8;
   // Pixels at this row or column and beyond add nothing
   localparam int MAX_SIDE        = 1024;

   localparam int KIND_W  = 2;
   localparam int SLOT_W  = 3;
   localparam int COORD_W = 10;
   localparam int PIX_W   = 8;
   localparam int SUM_W   = 28;
   localparam int SQ_W    = 2 * COORD_W;

   localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

   typedef enum logic [KIND_W-1:0] {
      OP_CLEAR = 2'd0,
      OP_LOAD  = 2'd1,
      OP_PIXEL = 2'd2
   } dcs_op_type;

   // One input word as it travels down the chain
   typedef struct packed {
      dcs_op_type         op;
      logic [SLOT_W-1:0]  slot;
      logic [COORD_W-1:0] center_x;
      logic [COORD_W-1:0] center_y;
      logic [COORD_W-1:0] radius;
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
      logic [PIX_W-1:0]   pixel_value;
      logic               last_pixel;
      logic               in_bounds;
   } dcs_word_type;

   // Running minimum carried alongside a word
   typedef struct packed {
      logic               found;
      logic [SLOT_W-1:0]  slot;
      logic [COORD_W-1:0] center_x;
      logic [COORD_W-1:0] center_y;
      logic [COORD_W-1:0] radius;
      logic [SUM_W-1:0]   sum;
   } dcs_best_type;

   // Square of the absolute difference of two coordinates
   function automatic logic [SQ_W-1:0] sq_diff(input logic [COORD_W-1:0] a,
                                               input logic [COORD_W-1:0] b);
      logic [COORD_W-1:0] d;
      d = (a >= b) ? (a - b) : (b - a);
      return SQ_W'(d) * SQ_W'(d);
   endfunction

endpackage

// ===== rtl/dcs_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcs_req_if / dcs_rsp_if
// Valid/ready channels for request words and result words.
// ----------------------------------------------------------------------------
interface dcs_req_if;
   logic                        valid;
   logic                        ready;
   logic [dcs_pkg::KIND_W-1:0]  kind;
   logic [dcs_pkg::SLOT_W-1:0]  slot;
   logic [dcs_pkg::COORD_W-1:0] center_x;
   logic [dcs_pkg::COORD_W-1:0] center_y;
   logic [dcs_pkg::COORD_W-1:0] radius;
   logic [dcs_pkg::COORD_W-1:0] row;
   logic [dcs_pkg::COORD_W-1:0] col;
   logic [dcs_pkg::PIX_W-1:0]   pixel_value;
   logic                        last_pixel;

   modport source (output valid, kind, slot, center_x, center_y, radius, row, col,
                   pixel_value, last_pixel, input ready);
   modport sink   (input valid, kind, slot, center_x, center_y, radius, row, col,
                   pixel_value, last_pixel, output ready);
endinterface

interface dcs_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        found;
   logic [dcs_pkg::SLOT_W-1:0]  best_slot;
   logic [dcs_pkg::COORD_W-1:0] best_center_x;
   logic [dcs_pkg::COORD_W-1:0] best_center_y;
   logic [dcs_pkg::COORD_W-1:0] best_radius;
   logic [dcs_pkg::SUM_W-1:0]   best_sum;

   modport source (output valid, found, best_slot, best_center_x, best_center_y,
                   best_radius, best_sum, input ready);
   modport sink   (input valid, found, best_slot, best_center_x, best_center_y,
                   best_radius, best_sum, output ready);
endinterface

// ===== rtl/dcs_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcs_cell
// One circle slot: holds the circle and its running sum, tests each passing
// pixel against the circle and folds its sum into the running minimum.
// ----------------------------------------------------------------------------
module dcs_cell #(
   parameter int INDEX = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  logic                  in_vld,
   input  dcs_pkg::dcs_word_type in_word,
   input  dcs_pkg::dcs_best_type in_best,
   output logic                  out_vld,
   output dcs_pkg::dcs_word_type out_word,
   output dcs_pkg::dcs_best_type out_best
);

   // Circle storage
   logic                        circ_vld_ff;
   logic [dcs_pkg::COORD_W-1:0] cx_ff, cy_ff, rad_ff;
   logic [dcs_pkg::SUM_W-1:0]   sum_ff, sum_in;

   // Stage A registers: squares and circle snapshot
   logic                        a_vld_ff;
   dcs_pkg::dcs_word_type       a_word_ff;
   dcs_pkg::dcs_best_type       a_best_ff;
   logic                        a_circ_vld_ff;
   logic [dcs_pkg::COORD_W-1:0] a_cx_ff, a_cy_ff, a_rad_ff;
   logic [dcs_pkg::SQ_W-1:0]    a_d2x_ff, a_d2y_ff, a_r2_ff;

   // Stage B registers: word and best handed to the next cell
   logic                        b_vld_ff;
   dcs_pkg::dcs_word_type       b_word_ff;
   dcs_pkg::dcs_best_type       b_best_ff;

   logic                        load_hit;
   logic                        a_load_hit;
   logic                        hit;
   logic [dcs_pkg::SUM_W:0]     acc;
   logic [dcs_pkg::SUM_W-1:0]   sum_upd;
   dcs_pkg::dcs_best_type       best_in;

   assign load_hit   = (in_word.op == dcs_pkg::OP_LOAD) && (int'(in_word.slot) == INDEX);
   assign a_load_hit = (a_word_ff.op == dcs_pkg::OP_LOAD) && (int'(a_word_ff.slot) == INDEX);

   // Update the stored circle on clear and on a load aimed at this slot
   always_ff @(posedge clock) begin
      if (reset) begin
         circ_vld_ff <= 1'b0;
         cx_ff       <= '0;
         cy_ff       <= '0;
         rad_ff      <= '0;
      end else if (adv && in_vld) begin
         if (in_word.op == dcs_pkg::OP_CLEAR) begin
            circ_vld_ff <= 1'b0;
         end else if (load_hit) begin
            circ_vld_ff <= 1'b1;
            cx_ff       <= in_word.center_x;
            cy_ff       <= in_word.center_y;
            rad_ff      <= in_word.radius;
         end
      end
   end

   // Stage A: square the distances and the radius
   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else if (adv) begin
         a_vld_ff <= in_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_word_ff     <= in_word;
         a_best_ff     <= in_best;
         a_circ_vld_ff <= circ_vld_ff;
         a_cx_ff       <= cx_ff;
         a_cy_ff       <= cy_ff;
         a_rad_ff      <= rad_ff;
         a_d2x_ff      <= dcs_pkg::sq_diff(in_word.col, cx_ff);
         a_d2y_ff      <= dcs_pkg::sq_diff(in_word.row, cy_ff);
         a_r2_ff       <= dcs_pkg::SQ_W'(rad_ff) * dcs_pkg::SQ_W'(rad_ff);
      end
   end

   // Stage B: inside test and saturating accumulate
   assign hit = (a_word_ff.op == dcs_pkg::OP_PIXEL) && a_word_ff.in_bounds && a_circ_vld_ff
                && (({1'b0, a_d2x_ff} + {1'b0, a_d2y_ff}) < {1'b0, a_r2_ff});
   assign acc     = {1'b0, sum_ff} + (dcs_pkg::SUM_W + 1)'(a_word_ff.pixel_value);
   assign sum_upd = !hit ? sum_ff
                  : (acc[dcs_pkg::SUM_W] ? dcs_pkg::SUM_MAX : acc[dcs_pkg::SUM_W-1:0]);

   // Fold this slot into the running minimum on the frame's last pixel
   always_comb begin
      best_in = a_best_ff;
      if ((a_word_ff.op == dcs_pkg::OP_PIXEL) && a_word_ff.last_pixel && a_circ_vld_ff
          && (!a_best_ff.found || (sum_upd < a_best_ff.sum))) begin
         best_in.found    = 1'b1;
         best_in.slot     = dcs_pkg::SLOT_W'(INDEX);
         best_in.center_x = a_cx_ff;
         best_in.center_y = a_cy_ff;
         best_in.radius   = a_rad_ff;
         best_in.sum      = sum_upd;
      end
   end

   // Next sum: zero on clear, on a load here and after the last pixel
   always_comb begin
      sum_in = sum_ff;
      if (adv && a_vld_ff) begin
         unique case (a_word_ff.op)
            dcs_pkg::OP_CLEAR: sum_in = '0;
            dcs_pkg::OP_LOAD:  sum_in = a_load_hit ? '0 : sum_ff;
            dcs_pkg::OP_PIXEL: sum_in = a_word_ff.last_pixel ? '0 : sum_upd;
            default:           sum_in = sum_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else begin
         sum_ff <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff <= 1'b0;
      end else if (adv) begin
         b_vld_ff <= a_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         b_word_ff <= a_word_ff;
         b_best_ff <= best_in;
      end
   end

   assign out_vld  = b_vld_ff;
   assign out_word = b_word_ff;
   assign out_best = b_best_ff;

endmodule

// ===== rtl/darkest_circle_selector_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// darkest_circle_selector_core
// Keeps candidate circles in slots, sums grey pixels inside each circle and
// reports the darkest circle at the end of every frame.
// ----------------------------------------------------------------------------
// Each request word (clear, load or pixel) enters a chain of MAX_CIRCLES cells,
// one per slot, and the block takes one word per clock while the chain is not
// stalled. A word on the frame's last pixel returns its result through the two
// register stages in each cell (squares, then compare and accumulate) and then
// the result register, the first stage taking the word at the accepting edge.
// Ties go to the lowest slot. The request side holds off only while a result
// waits unread and the next last-pixel word has reached the end of the chain.
module darkest_circle_selector_core #(
   parameter int MAX_CIRCLES = dcs_pkg::MAX_CIRCLES_DEF
) (
   input logic       clock,
   input logic       reset,
   dcs_req_if.sink   req,
   dcs_rsp_if.source rsp
);

   logic                  vld  [0:MAX_CIRCLES];
   dcs_pkg::dcs_word_type word [0:MAX_CIRCLES];
   dcs_pkg::dcs_best_type best [0:MAX_CIRCLES];

   logic                  adv;
   logic                  stall;
   logic                  known_kind;
   logic                  tail_last;
   logic                  rsp_vld_ff;
   dcs_pkg::dcs_best_type rsp_best_ff;

   // Entry: drop unused kinds, flag out-of-range pixels
   assign known_kind = (req.kind == dcs_pkg::OP_CLEAR) || (req.kind == dcs_pkg::OP_LOAD)
                       || (req.kind == dcs_pkg::OP_PIXEL);
   assign vld[0]  = req.valid && adv && known_kind;

   always_comb begin
      word[0].op          = dcs_pkg::dcs_op_type'(req.kind);
      word[0].slot        = req.slot;
      word[0].center_x    = req.center_x;
      word[0].center_y    = req.center_y;
      word[0].radius      = req.radius;
      word[0].row         = req.row;
      word[0].col         = req.col;
      word[0].pixel_value = req.pixel_value;
      word[0].last_pixel  = req.last_pixel;
      word[0].in_bounds   = (int'(req.row) < dcs_pkg::MAX_SIDE)
                            && (int'(req.col) < dcs_pkg::MAX_SIDE);
   end
   assign best[0] = '0;

   // Chain of slot cells
   for (genvar i = 0; i < MAX_CIRCLES; i++) begin : g_cell
      dcs_cell #(
         .INDEX (i)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .adv      (adv),
         .in_vld   (vld[i]),
         .in_word  (word[i]),
         .in_best  (best[i]),
         .out_vld  (vld[i+1]),
         .out_word (word[i+1]),
         .out_best (best[i+1])
      );
   end

   // Hold the chain only when a second result would overrun the output register
   assign tail_last = vld[MAX_CIRCLES] && (word[MAX_CIRCLES].op == dcs_pkg::OP_PIXEL)
                      && word[MAX_CIRCLES].last_pixel;
   assign stall     = rsp_vld_ff && !rsp.ready && tail_last;
   assign adv       = !stall;
   assign req.ready = adv;

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (adv && tail_last) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && tail_last) begin
         rsp_best_ff <= best[MAX_CIRCLES];
      end
   end

   assign rsp.valid         = rsp_vld_ff;
   assign rsp.found         = rsp_best_ff.found;
   assign rsp.best_slot     = rsp_best_ff.slot;
   assign rsp.best_center_x = rsp_best_ff.center_x;
   assign rsp.best_center_y = rsp_best_ff.center_y;
   assign rsp.best_radius   = rsp_best_ff.radius;
   assign rsp.best_sum      = rsp_best_ff.sum;

endmodule

// ===== rtl/dcs_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcs_checker
// Port-level checks on the result channel of the darkest circle selector.
// ----------------------------------------------------------------------------
module dcs_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic                        found,
   input logic [dcs_pkg::SLOT_W-1:0]  best_slot,
   input logic [dcs_pkg::COORD_W-1:0] best_center_x,
   input logic [dcs_pkg::COORD_W-1:0] best_center_y,
   input logic [dcs_pkg::COORD_W-1:0] best_radius,
   input logic [dcs_pkg::SUM_W-1:0]   best_sum
);

   // A stalled result word holds its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(best_sum) && $stable(best_slot)
                                  && $stable(found))
      else $error("result word changed while stalled");

   // A not-found result carries all-zero fields
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !found |-> best_slot == '0 && best_center_x == '0
                              && best_center_y == '0 && best_radius == '0 && best_sum == '0)
      else $error("not-found result with nonzero fields");

   // Reset leaves no result pending
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind darkest_circle_selector_core dcs_checker u_dcs_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp.valid),
   .rsp_ready     (rsp.ready),
   .found         (rsp.found),
   .best_slot     (rsp.best_slot),
   .best_center_x (rsp.best_center_x),
   .best_center_y (rsp.best_center_y),
   .best_radius   (rsp.best_radius),
   .best_sum      (rsp.best_sum)
);

// ===== sim/darkest_result_tracker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// darkest_result_tracker
// Watches the request and result channels of the darkest circle selector,
// keeps its own copy of the circle slots and their running sums, works out
// the darkest circle at each frame end and compares it with the result word.
// ----------------------------------------------------------------------------
module darkest_result_tracker #(
   parameter int MAX_CIRCLES = dcs_pkg::MAX_CIRCLES_DEF
) (
   input  logic clock,
   input  logic reset,
   dcs_req_if   req_mon,
   dcs_rsp_if   rsp_mon,
   output int   fail_count,
   output int   pending_count
);
   import dcs_pkg::*;

   // Slot contents as the block should hold them
   logic               circ_live [MAX_CIRCLES];
   logic [COORD_W-1:0] circ_cx   [MAX_CIRCLES];
   logic [COORD_W-1:0] circ_cy   [MAX_CIRCLES];
   logic [COORD_W-1:0] circ_r    [MAX_CIRCLES];
   logic [SUM_W-1:0]   circ_sum  [MAX_CIRCLES];

   // Darkest circle owed for each frame end, oldest first
   dcs_best_type       darkest_q [$];
   int                 miss_total = 0;

   // Strict test: squared distance below squared radius
   function automatic logic pixel_inside(input int idx,
                                         input logic [COORD_W-1:0] row,
                                         input logic [COORD_W-1:0] col);
      logic [COORD_W-1:0] dx;
      logic [COORD_W-1:0] dy;
      logic [SQ_W:0]      span_sq;
      logic [SQ_W:0]      lim;
      dx      = (col >= circ_cx[idx]) ? col - circ_cx[idx] : circ_cx[idx] - col;
      dy      = (row >= circ_cy[idx]) ? row - circ_cy[idx] : circ_cy[idx] - row;
      span_sq = (SQ_W+1)'(dx) * (SQ_W+1)'(dx) + (SQ_W+1)'(dy) * (SQ_W+1)'(dy);
      lim     = (SQ_W+1)'(circ_r[idx]) * (SQ_W+1)'(circ_r[idx]);
      return span_sq < lim;
   endfunction

   // Scan upward from slot 0; only a strictly smaller sum takes over
   function automatic dcs_best_type pick_darkest();
      dcs_best_type best;
      best = '0;
      for (int i = 0; i < MAX_CIRCLES; i++) begin
         if (circ_live[i] && (!best.found || circ_sum[i] < best.sum)) begin
            best.found    = 1'b1;
            best.slot     = SLOT_W'(i);
            best.center_x = circ_cx[i];
            best.center_y = circ_cy[i];
            best.radius   = circ_r[i];
            best.sum      = circ_sum[i];
         end
      end
      return best;
   endfunction

   // Apply one accepted request word to the slot copy
   task automatic absorb_word();
      logic [SUM_W:0] grown;
      case (req_mon.kind)
         OP_CLEAR: begin
            for (int i = 0; i < MAX_CIRCLES; i++) begin
               circ_live[i] = 1'b0;
               circ_sum[i]  = '0;
            end
         end
         OP_LOAD: begin
            if (int'(req_mon.slot) < MAX_CIRCLES) begin
               circ_live[req_mon.slot] = 1'b1;
               circ_cx[req_mon.slot]   = req_mon.center_x;
               circ_cy[req_mon.slot]   = req_mon.center_y;
               circ_r[req_mon.slot]    = req_mon.radius;
               circ_sum[req_mon.slot]  = '0;
            end
         end
         OP_PIXEL: begin
            // off-image pixels add nothing but still close the frame
            if (int'(req_mon.row) < MAX_SIDE && int'(req_mon.col) < MAX_SIDE) begin
               for (int i = 0; i < MAX_CIRCLES; i++) begin
                  if (circ_live[i] && pixel_inside(i, req_mon.row, req_mon.col)) begin
                     grown       = {1'b0, circ_sum[i]} + (SUM_W+1)'(req_mon.pixel_value);
                     circ_sum[i] = (grown > {1'b0, SUM_MAX}) ? SUM_MAX : grown[SUM_W-1:0];
                  end
               end
            end
            if (req_mon.last_pixel) begin
               darkest_q.insert(darkest_q.size(), pick_darkest());
               for (int i = 0; i < MAX_CIRCLES; i++) circ_sum[i] = '0;
            end
         end
         default: ;
      endcase
   endtask

   // Compare one result word with the oldest owed result
   task automatic check_result();
      dcs_best_type got;
      dcs_best_type want;
      got.found    = rsp_mon.found;
      got.slot     = rsp_mon.best_slot;
      got.center_x = rsp_mon.best_center_x;
      got.center_y = rsp_mon.best_center_y;
      got.radius   = rsp_mon.best_radius;
      got.sum      = rsp_mon.best_sum;
      if (darkest_q.size() == 0) begin
         if (miss_total < 10)
            $display("%t: result word with none owed: found=%0d slot=%0d", $realtime,
                     got.found, got.slot);
         miss_total++;
      end else begin
         want = darkest_q.pop_front();
         if (got !== want) begin
            if (miss_total < 10)
               $display({"%t: mismatch exp found=%0d slot=%0d cx=%0d cy=%0d r=%0d sum=%0d",
                         " | got found=%0d slot=%0d cx=%0d cy=%0d r=%0d sum=%0d"},
                        $realtime, want.found, want.slot, want.center_x, want.center_y,
                        want.radius, want.sum, got.found, got.slot, got.center_x,
                        got.center_y, got.radius, got.sum);
            miss_total++;
         end
      end
   endtask

   // Sample both channels at each edge
   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_CIRCLES; i++) begin
            circ_live[i] = 1'b0;
            circ_cx[i]   = '0;
            circ_cy[i]   = '0;
            circ_r[i]    = '0;
            circ_sum[i]  = '0;
         end
         darkest_q.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) check_result();
         if (req_mon.valid && req_mon.ready) absorb_word();
      end
      fail_count    <= miss_total;
      pending_count <= darkest_q.size();
   end

endmodule

// ===== sim/tb_darkest_circle_selector_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_darkest_circle_selector_core
// Drives circle loads, clears and pixel frames into the selector: a directed
// set of corner cases, one long frame sent with no idling, then random
// frames, with random gaps on the request side and stalls on the result side.
// ----------------------------------------------------------------------------
module tb_darkest_circle_selector_core;
   import dcs_pkg::*;

   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
   localparam int ITEM_TARGET  = 1650;
   localparam int STALL_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 2 * MAX_CIRCLES_DEF + 8;
   // Length of the frame sent with no idling on either side
   localparam int QUIET_PIXELS = 300;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic quiet = 1'b0;
   int   mismatches;
   int   results_due;

   // Circles last loaded, used only to aim pixels at them
   logic gen_used [MAX_CIRCLES_DEF];
   int   gen_cx   [MAX_CIRCLES_DEF];
   int   gen_cy   [MAX_CIRCLES_DEF];
   int   gen_r    [MAX_CIRCLES_DEF];

   dcs_req_if req_ch ();
   dcs_rsp_if rsp_ch ();

   darkest_circle_selector_core uut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   darkest_result_tracker tracker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_ch),
      .rsp_mon       (rsp_ch),
      .fail_count    (mismatches),
      .pending_count (results_due)
   );

   always #5 clock = ~clock;

   // Stall the result side at random, about 9 percent of the time
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         rsp_ch.ready <= quiet || ($urandom_range(99) >= 9);
      end
   end

   // Present one request word and hold it until accepted
   task automatic send_word(input logic [KIND_W-1:0]  kind,
                            input logic [SLOT_W-1:0]  slot,
                            input logic [COORD_W-1:0] cx,
                            input logic [COORD_W-1:0] cy,
                            input logic [COORD_W-1:0] r,
                            input logic [COORD_W-1:0] row,
                            input logic [COORD_W-1:0] col,
                            input logic [PIX_W-1:0]   val,
                            input logic               last);
      while (!quiet && $urandom_range(99) < 9) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.kind        <= kind;
      req_ch.slot        <= slot;
      req_ch.center_x    <= cx;
      req_ch.center_y    <= cy;
      req_ch.radius      <= r;
      req_ch.row         <= row;
      req_ch.col         <= col;
      req_ch.pixel_value <= val;
      req_ch.last_pixel  <= last;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // Load a circle; the pixel fields carry noise
   task automatic load_circle(input int slot, input int cx, input int cy, input int r);
      send_word(OP_LOAD, SLOT_W'(slot), COORD_W'(cx), COORD_W'(cy), COORD_W'(r),
                COORD_W'($urandom), COORD_W'($urandom), PIX_W'($urandom), 1'($urandom));
      gen_used[slot] = 1'b1;
      gen_cx[slot]   = cx;
      gen_cy[slot]   = cy;
      gen_r[slot]    = r;
   endtask

   // Send a pixel; the circle fields carry noise
   task automatic put_pixel(input int row, input int col, input int val, input logic last);
      send_word(OP_PIXEL, SLOT_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
                COORD_W'($urandom), COORD_W'(row), COORD_W'(col), PIX_W'(val), last);
   endtask

   task automatic wipe_slots();
      send_word(OP_CLEAR, SLOT_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
                COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
                PIX_W'($urandom), 1'($urandom));
      for (int i = 0; i < MAX_CIRCLES_DEF; i++) gen_used[i] = 1'b0;
   endtask

   // Hold the request side until every owed result has come back
   task automatic wait_results();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (results_due != 0);
   endtask

   // Coordinate within one more than a radius of a center, kept on the image
   function automatic int jitter_around(input int c, input int r);
      int v;
      v = c + int'($urandom_range(2 * r + 2)) - (r + 1);
      if (v < 0) v = 0;
      if (v > MAX_SIDE - 1) v = MAX_SIDE - 1;
      return v;
   endfunction

   // Cut the run when nothing moves on either channel for too long
   initial begin
      int stuck_cycles;
      stuck_cycles = 0;
      while (stuck_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            stuck_cycles = 0;
         else
            stuck_cycles++;
      end
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      int   done_items;
      int   s;
      int   t;
      int   nload;
      int   npix;
      logic lastp;

      for (int i = 0; i < MAX_CIRCLES_DEF; i++) gen_used[i] = 1'b0;
      req_ch.valid       = 1'b0;
      req_ch.kind        = '0;
      req_ch.slot        = '0;
      req_ch.center_x    = '0;
      req_ch.center_y    = '0;
      req_ch.radius      = '0;
      req_ch.row         = '0;
      req_ch.col         = '0;
      req_ch.pixel_value = '0;
      req_ch.last_pixel  = 1'b0;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // frame end with no circle loaded: not found
      put_pixel(0, 0, 255, 1'b1);
      // unused kind is dropped, last mark and all
      send_word(KIND_UNUSED, '1, '1, '1, '1, 10'd5, 10'd5, 8'd255, 1'b1);
      // zero radius, far corner, small circle
      load_circle(0, 0, 0, 0);
      load_circle(7, 1023, 1023, 1023);
      load_circle(3, 512, 512, 5);
      put_pixel(512, 512, 255, 1'b0);
      put_pixel(512, 517, 200, 1'b0);   // exactly on the rim: outside
      put_pixel(0, 0, 255, 1'b0);
      put_pixel(1023, 1023, 255, 1'b1);
      // equal sums in three slots: lowest index wins
      load_circle(0, 100, 100, 2);
      put_pixel(100, 101, 9, 1'b0);
      put_pixel(513, 512, 9, 1'b1);
      // reload mid-frame drops that slot's sum
      put_pixel(100, 100, 50, 1'b0);
      load_circle(0, 100, 100, 2);
      put_pixel(100, 100, 7, 1'b1);
      // clear empties every slot
      wipe_slots();
      put_pixel(512, 512, 255, 1'b1);
      load_circle(5, 1023, 0, 1);
      put_pixel(0, 1023, 255, 1'b1);
      wait_results();

      // long frame with no idling: two identical circles tie
      quiet <= 1'b1;
      wipe_slots();
      load_circle(3, 512, 512, 1023);
      load_circle(6, 512, 512, 1023);
      for (int n = 0; n < QUIET_PIXELS; n++)
         put_pixel($urandom_range(543, 480), $urandom_range(543, 480), 255,
                   n == QUIET_PIXELS - 1);
      wait_results();
      quiet <= 1'b0;

      // random frames: optional clear, a few loads, then a short pixel run
      done_items = 0;
      while (done_items < ITEM_TARGET - QUIET_PIXELS) begin
         if ($urandom_range(99) < 15) begin
            wipe_slots();
            done_items++;
         end
         nload = ($urandom_range(4) == 0) ? 0 : int'($urandom_range(3, 1));
         repeat (nload) begin
            s = $urandom_range(MAX_CIRCLES_DEF - 1);
            t = $urandom_range(MAX_CIRCLES_DEF - 1);
            if ($urandom_range(9) == 0 && gen_used[t])
               load_circle(s, gen_cx[t], gen_cy[t], gen_r[t]);   // twin: forces a tie
            else
               load_circle(s, $urandom_range(1023), $urandom_range(1023),
                           ($urandom_range(4) == 0) ? $urandom_range(1023)
                                                    : $urandom_range(40));
            done_items++;
         end
         npix = $urandom_range(12, 1);
         for (int p = 0; p < npix; p++) begin
            if ($urandom_range(19) == 0)
               send_word(KIND_UNUSED, SLOT_W'($urandom), COORD_W'($urandom),
                         COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
                         COORD_W'($urandom), PIX_W'($urandom), 1'($urandom));
            t     = $urandom_range(MAX_CIRCLES_DEF - 1);
            lastp = (p == npix - 1) || ($urandom_range(29) == 0);
            if (gen_used[t] && $urandom_range(9) < 7)
               put_pixel(jitter_around(gen_cy[t], gen_r[t]),
                         jitter_around(gen_cx[t], gen_r[t]), $urandom_range(255), lastp);
            else
               put_pixel($urandom_range(1023), $urandom_range(1023), $urandom_range(255),
                         lastp);
            done_items++;
         end
         if ($urandom_range(24) == 0) wait_results();
      end

      // drain, then let the pipeline settle
      wait_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && results_due == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
